// File: hdl/imrot_pkg.sv
package imrot_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int CFG_DATA_W  = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_TURN   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_DATA
  } bk_state_t;

  // One queued request: load a pixel or emit the next rotated one
  typedef struct packed {
    logic                emit;
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

endpackage

// File: hdl/imrot_ram.sv
module imrot_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/imrot_front.sv
module imrot_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [imrot_pkg::SAMPLE_W-1:0] in_red_in,
  input  logic [imrot_pkg::SAMPLE_W-1:0] in_green_in,
  input  logic [imrot_pkg::SAMPLE_W-1:0] in_blue_in,
  output imrot_pkg::q_head_t            q_head,
  input  logic                          q_pop
);

  import imrot_pkg::*;

  item_t             ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  item_t             new_item;

  assign in_stall = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;

  always_comb begin
    new_item.emit  = in_action;
    new_item.red   = in_red_in;
    new_item.green = in_green_in;
    new_item.blue  = in_blue_in;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= new_item;
    end
  end

  assign q_head.valid = (cnt_r != '0);
  assign q_head.item  = ent_r[rd_ptr_r];

endmodule

// File: hdl/imrot_back.sv
module imrot_back #(
  parameter int MAX_DIM     = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [$clog2(MAX_DIM+1)-1:0]        dim_w,
  input  logic [$clog2(MAX_DIM+1)-1:0]        dim_h,
  input  logic [$clog2(MAX_DIM*MAX_DIM+1)-1:0] total,
  input  logic                                turn_right,
  input  imrot_pkg::q_head_t                  q_head,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [imrot_pkg::SAMPLE_W-1:0]      out_red_out,
  output logic [imrot_pkg::SAMPLE_W-1:0]      out_green_out,
  output logic [imrot_pkg::SAMPLE_W-1:0]      out_blue_out,
  output logic                                out_last,
  output logic                                out_not_ready
);

  import imrot_pkg::*;

  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int PW    = $clog2(MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int MW    = PW + DW + 1;
  localparam int SB    = SAMPLE_BITS;

  bk_state_t          state_r, state_nxt;
  logic [CW-1:0]      load_cnt_r, load_cnt_nxt;
  logic [PW-1:0]      row_r, row_nxt;
  logic [PW-1:0]      col_r, col_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic               last_r, last_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] red_r, red_nxt;
  logic [SAMPLE_W-1:0] green_r, green_nxt;
  logic [SAMPLE_W-1:0] blue_r, blue_nxt;
  logic               last_out_r, last_out_nxt;
  logic               nrdy_r, nrdy_nxt;

  logic               out_free;
  logic               frame_full;
  logic               outside;
  logic [PW-1:0]      eff_row, eff_col;
  logic [PW-1:0]      mul_a, mul_b;
  logic [MW-1:0]      src;
  logic               col_end, row_end;
  logic               wrap_frame;
  logic               ram_we, ram_re;
  logic [3*SB-1:0]    ram_wdata, ram_rdata;

  assign out_free   = !out_valid_r || !out_stall;
  assign frame_full = (load_cnt_r >= total);
  assign outside    = (DW'(row_r) >= dim_w) || (DW'(col_r) >= dim_h);
  assign eff_row    = outside ? '0 : row_r;
  assign eff_col    = outside ? '0 : col_r;
  assign mul_a      = turn_right ? PW'(dim_h - DW'(1) - DW'(eff_col)) : eff_col;
  assign mul_b      = turn_right ? eff_row : PW'(dim_w - DW'(1) - DW'(eff_row));
  assign src        = MW'(mul_a) * MW'(dim_w) + MW'(mul_b);
  assign col_end    = (DW'(eff_col) + DW'(1) >= dim_h);
  assign row_end    = (DW'(eff_row) + DW'(1) >= dim_w);
  assign ram_wdata  = {q_head.item.red[SB-1:0], q_head.item.green[SB-1:0],
                       q_head.item.blue[SB-1:0]};

  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    addr_nxt      = addr_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && out_stall;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    last_out_nxt  = last_out_r;
    nrdy_nxt      = nrdy_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    wrap_frame    = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_head.valid && out_free) begin
          q_pop = 1'b1;
          if (q_head.item.emit && frame_full) begin
            // advance the rotated raster position and fetch the source pixel
            addr_nxt  = AW'(src);
            state_nxt = BK_READ;
            if (col_end) begin
              col_nxt = '0;
              if (row_end) begin
                wrap_frame   = 1'b1;
                last_nxt     = 1'b1;
                row_nxt      = '0;
                load_cnt_nxt = '0;
              end else begin
                last_nxt = 1'b0;
                row_nxt  = eff_row + 1'b1;
              end
            end else begin
              last_nxt = 1'b0;
              row_nxt  = eff_row;
              col_nxt  = eff_col + 1'b1;
            end
          end else begin
            if (!q_head.item.emit && !frame_full) begin
              ram_we       = 1'b1;
              load_cnt_nxt = load_cnt_r + 1'b1;
            end
            out_valid_nxt = 1'b1;
            red_nxt       = '0;
            green_nxt     = '0;
            blue_nxt      = '0;
            last_out_nxt  = 1'b0;
            nrdy_nxt      = q_head.item.emit;
          end
        end
      end
      BK_READ: begin
        ram_re    = 1'b1;
        state_nxt = BK_DATA;
      end
      BK_DATA: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          red_nxt       = SAMPLE_W'(ram_rdata[3*SB-1:2*SB]);
          green_nxt     = SAMPLE_W'(ram_rdata[2*SB-1:SB]);
          blue_nxt      = SAMPLE_W'(ram_rdata[SB-1:0]);
          last_out_nxt  = last_r;
          nrdy_nxt      = 1'b0;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      load_cnt_r  <= '0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    last_r     <= last_nxt;
    red_r      <= red_nxt;
    green_r    <= green_nxt;
    blue_r     <= blue_nxt;
    last_out_r <= last_out_nxt;
    nrdy_r     <= nrdy_nxt;
  end

  imrot_ram #(
    .WIDTH (3 * SB),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(load_cnt_r)),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_red_out   = red_r;
  assign out_green_out = green_r;
  assign out_blue_out  = blue_r;
  assign out_last      = last_out_r;
  assign out_not_ready = nrdy_r;

  a_read_then_data: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_READ |=> state_r == BK_DATA)
    else $error("frame store read not followed by data stage");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != BK_IDLE |-> !q_pop)
    else $error("queue popped while a fetch is in flight");

  a_last_not_nrdy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(last_out_r && nrdy_r))
    else $error("last flagged on a not-ready result");

  a_wrap_clears: assert property (@(posedge clk) disable iff (!rst_n)
    wrap_frame |=> (load_cnt_r == '0) && (row_r == '0) && (col_r == '0))
    else $error("frame wrap did not clear counters");

endmodule

// File: hdl/image_rotate_quarter_turn_unit.sv
// Quarter-turn frame rotation engine.
// A load or a not-ready emit passes from the queue head to the output register;
// an emit on a full frame first passes the address register and the registered
// frame store read. One load per cycle while the output is not stalled; a rotated
// pixel is done with its read and data states before the next request is popped.
// Reset clears the queue, counters and output; registers return to 256 x 256, left.
module image_rotate_quarter_turn_unit #(
  parameter int MAX_DIM     = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // pixel request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic [imrot_pkg::SAMPLE_W-1:0]    in_red_in,
  input  logic [imrot_pkg::SAMPLE_W-1:0]    in_green_in,
  input  logic [imrot_pkg::SAMPLE_W-1:0]    in_blue_in,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [imrot_pkg::SAMPLE_W-1:0]    out_red_out,
  output logic [imrot_pkg::SAMPLE_W-1:0]    out_green_out,
  output logic [imrot_pkg::SAMPLE_W-1:0]    out_blue_out,
  output logic                              out_last,
  output logic                              out_not_ready,
  // register write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [imrot_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [imrot_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import imrot_pkg::*;

  localparam int DW        = $clog2(MAX_DIM + 1);
  localparam int CW        = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int RESET_DIM = (MAX_DIM < 256) ? MAX_DIM : 256;

  // Sizes are kept already clamped: zero reads as one, anything above the
  // largest frame reads as the largest frame.
  logic [DW-1:0] dim_w_r;
  logic [DW-1:0] dim_h_r;
  logic          turn_r;
  logic [CW-1:0] total_r, total_nxt;
  logic          cfg_we;
  q_head_t       q_head;
  logic          q_pop;

  function automatic logic [DW-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
    logic [DW-1:0] res;
    if (v == '0) begin
      res = DW'(1);
    end else if (int'(v) > MAX_DIM) begin
      res = DW'(MAX_DIM);
    end else begin
      res = DW'(v);
    end
    return res;
  endfunction

  // Register writes are always taken; writes to an unused index are dropped.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_w_r <= DW'(RESET_DIM);
      dim_h_r <= DW'(RESET_DIM);
      turn_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:  dim_w_r <= clamp_dim(cfg_data);
        CFG_HEIGHT: dim_h_r <= clamp_dim(cfg_data);
        CFG_TURN:   turn_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Total is registered from the sizes; only change sizes while idle (not checked).
  assign total_nxt = CW'(dim_w_r) * CW'(dim_h_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= CW'(RESET_DIM * RESET_DIM);
    end else begin
      total_r <= total_nxt;
    end
  end

  // Front: take items into a short queue so the back end can stall on its own.
  imrot_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_action   (in_action),
    .in_red_in   (in_red_in),
    .in_green_in (in_green_in),
    .in_blue_in  (in_blue_in),
    .q_head      (q_head),
    .q_pop       (q_pop)
  );

  // Back: frame store, load counter, rotated raster walk and output register.
  imrot_back #(
    .MAX_DIM     (MAX_DIM),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .dim_w         (dim_w_r),
    .dim_h         (dim_h_r),
    .total         (total_r),
    .turn_right    (turn_r),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_last      (out_last),
    .out_not_ready (out_not_ready)
  );

endmodule

// File: sim/tb_image_rotate_quarter_turn_unit.sv
module tb_image_rotate_quarter_turn_unit;
  import imrot_pkg::*;

  localparam int MAX_DIM      = 256;
  localparam int SAMPLE_BITS  = 16;
  localparam int STORE_DEPTH  = MAX_DIM * MAX_DIM;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

  // request codes on in_action
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EMIT = 1'b1;

  // index with no register behind it; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int DRAIN_CYCLES   = 6;    // spare cycles after the last expected pixel drains
  localparam int HOLD_CYCLES    = 300;  // long receiver hold-off for back-pressure
  localparam int RANDOM_ITEMS   = 1350;
  localparam int MIN_PHASES     = 8;

  // sender idle / receiver stall percentages per idling mode
  localparam int SEND_IDLE_PCT [4] = '{0, 87, 0, 6};
  localparam int RECV_STALL_PCT[4] = '{0, 0, 87, 6};

  typedef struct packed {
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic                last;
    logic                not_ready;
  } rot_pixel_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
  } stored_pixel_t;

  // one step of the directed script: a register write or a request
  typedef struct {
    bit                     is_cfg;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    item_t                  req;
    bit                     typed;
    rot_pixel_t             want;
  } script_row_t;

  localparam rot_pixel_t BLANK_PIXEL     = '0;
  localparam rot_pixel_t NOT_READY_PIXEL = '{red: '0, green: '0, blue: '0,
                                             last: 1'b0, not_ready: 1'b1};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic                  in_action    = ACT_LOAD;
  logic [SAMPLE_W-1:0]   in_red_in    = '0;
  logic [SAMPLE_W-1:0]   in_green_in  = '0;
  logic [SAMPLE_W-1:0]   in_blue_in   = '0;

  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic [SAMPLE_W-1:0]   out_red_out;
  logic [SAMPLE_W-1:0]   out_green_out;
  logic [SAMPLE_W-1:0]   out_blue_out;
  logic                  out_last;
  logic                  out_not_ready;

  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = CFG_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  // shadow copy of the rotation engine
  stored_pixel_t         frame_store [STORE_DEPTH];
  int unsigned           pix_count    = 0;
  int unsigned           rot_row      = 0;
  int unsigned           rot_col      = 0;
  logic [CFG_DATA_W-1:0] reg_width    = CFG_DATA_W'(MAX_DIM);
  logic [CFG_DATA_W-1:0] reg_height   = CFG_DATA_W'(MAX_DIM);
  logic                  reg_turn     = 1'b0;

  rot_pixel_t            expected_pixels[$];
  int                    mismatch_count = 0;

  // idling knobs, written by the stimulus, read by the drivers
  int                    send_idle_pct  = 0;
  int                    recv_stall_pct = 0;
  int                    hold_requests  = 0;

  image_rotate_quarter_turn_unit #(
    .MAX_DIM     (MAX_DIM),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_last      (out_last),
    .out_not_ready (out_not_ready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  // Give out-of-range sizes their effective value: zero acts as one,
  // anything above the largest frame acts as the largest frame.
  function automatic int unsigned dim_eff(input logic [CFG_DATA_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // Advance the shadow engine by one request and return the pixel it yields.
  function automatic rot_pixel_t rotate_step(input item_t req);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned src;
    rot_pixel_t  res;
    w     = dim_eff(reg_width);
    h     = dim_eff(reg_height);
    total = w * h;
    res   = '0;
    if (req.emit == ACT_LOAD) begin
      // store in raster order; drop once the frame is full
      if (pix_count < total) begin
        frame_store[pix_count] = '{req.red & SAMPLE_MASK, req.green & SAMPLE_MASK,
                                   req.blue & SAMPLE_MASK};
        pix_count++;
      end
      return res;
    end
    if (pix_count < total) begin
      res.not_ready = 1'b1;
      return res;
    end
    // a size change can leave the position outside the rotated frame
    if (rot_row >= w || rot_col >= h) begin
      rot_row = 0;
      rot_col = 0;
    end
    if (reg_turn)
      src = (h - 1 - rot_col) * w + rot_row;
    else
      src = rot_col * w + (w - 1 - rot_row);
    src = src % STORE_DEPTH;
    res.red   = frame_store[src].red;
    res.green = frame_store[src].green;
    res.blue  = frame_store[src].blue;
    // rotated frame is h wide and w tall; clear everything after its last pixel
    if (rot_col + 1 >= h) begin
      rot_col = 0;
      if (rot_row + 1 >= w) begin
        res.last  = 1'b1;
        rot_row   = 0;
        pix_count = 0;
      end else begin
        rot_row++;
      end
    end else begin
      rot_col++;
    end
    return res;
  endfunction

  function automatic item_t random_req(input logic act);
    item_t req;
    req.emit  = act;
    req.red   = SAMPLE_W'($urandom);
    req.green = SAMPLE_W'($urandom);
    req.blue  = SAMPLE_W'($urandom);
    return req;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Offer one request, hold it until accepted, then queue what it should yield.
  // Valid stays high on return so a following request can go straight out.
  task automatic push_request(input item_t req, input bit typed, input rot_pixel_t want);
    rot_pixel_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= req.emit;
    in_red_in   <= req.red;
    in_green_in <= req.green;
    in_blue_in  <= req.blue;
    do @(posedge clk); while (in_stall);
    predicted = rotate_step(req);
    expected_pixels.push_back(typed ? want : predicted);
  endtask

  // Drop valid, let every pending pixel drain, then give the pipe a few spare cycles.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WIDTH:  reg_width  = data;
      CFG_HEIGHT: reg_height = data;
      CFG_TURN:   reg_turn   = data[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: stall per the current mode, or hold off for a long stretch on request.
  int hold_served = 0;
  int hold_left   = 0;
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Compare every accepted pixel against the oldest expectation, field by field.
  always @(posedge clk) begin
    rot_pixel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("pixel returned with nothing expected");
      end else begin
        want = expected_pixels.pop_front();
        if (out_red_out !== want.red)
          report_mismatch($sformatf("red got %h want %h", out_red_out, want.red));
        if (out_green_out !== want.green)
          report_mismatch($sformatf("green got %h want %h", out_green_out, want.green));
        if (out_blue_out !== want.blue)
          report_mismatch($sformatf("blue got %h want %h", out_blue_out, want.blue));
        if (out_last !== want.last)
          report_mismatch($sformatf("last got %b want %b", out_last, want.last));
        if (out_not_ready !== want.not_ready)
          report_mismatch($sformatf("not_ready got %b want %b", out_not_ready,
                                    want.not_ready));
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #4000000;
    $display("image_rotate_quarter_turn_unit regression: fail");
    $finish;
  end

  initial begin
    script_row_t           script_rows[$];
    script_row_t           row;
    int unsigned           phase;
    int unsigned           sent;
    int unsigned           total;
    int unsigned           n;
    logic [CFG_DATA_W-1:0] wd;
    logic [CFG_DATA_W-1:0] ht;

    // Directed script. Typed expectations only where the answer is obvious:
    // loads always return a blank pixel, early emits flag not-ready.

    // reset frame is 256 x 256 and empty: emit is refused
    row = '{0, CFG_WIDTH, '0, '{ACT_EMIT, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1, NOT_READY_PIXEL};
    script_rows.push_back(row);
    row = '{0, CFG_WIDTH, '0, '{ACT_LOAD, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1, BLANK_PIXEL};
    script_rows.push_back(row);
    // shrink to 2 x 1 with one pixel already held; height zero acts as one
    script_rows.push_back('{1, CFG_WIDTH,  9'd2, '0, 0, BLANK_PIXEL});
    script_rows.push_back('{1, CFG_HEIGHT, 9'd0, '0, 0, BLANK_PIXEL});
    script_rows.push_back('{1, CFG_TURN,   9'd0, '0, 0, BLANK_PIXEL});
    row = '{0, CFG_WIDTH, '0, '{ACT_LOAD, 16'h0000, 16'h0000, 16'h0000}, 1, BLANK_PIXEL};
    script_rows.push_back(row);
    // frame full: this load is dropped
    row = '{0, CFG_WIDTH, '0, '{ACT_LOAD, 16'hA5A5, 16'h5A5A, 16'h0F0F}, 1, BLANK_PIXEL};
    script_rows.push_back(row);
    script_rows.push_back('{0, CFG_WIDTH, '0, '{ACT_EMIT, 16'h1111, 16'h2222, 16'h3333},
                            0, BLANK_PIXEL});
    script_rows.push_back('{0, CFG_WIDTH, '0, '{ACT_EMIT, 16'h0000, 16'h0000, 16'h0000},
                            0, BLANK_PIXEL});
    // 3 x 2 turning right, with an early emit before the last load
    script_rows.push_back('{1, CFG_WIDTH,  9'd3, '0, 0, BLANK_PIXEL});
    script_rows.push_back('{1, CFG_HEIGHT, 9'd2, '0, 0, BLANK_PIXEL});
    script_rows.push_back('{1, CFG_TURN,   9'd1, '0, 0, BLANK_PIXEL});
    for (int i = 0; i < 5; i++) begin
      row = '{0, CFG_WIDTH, '0, '{ACT_LOAD, SAMPLE_W'(16'h1000 * i + 16'h0101),
              SAMPLE_W'(16'hF000 - 16'h1000 * i), SAMPLE_W'(16'h8001 + i)}, 1, BLANK_PIXEL};
      script_rows.push_back(row);
    end
    script_rows.push_back('{0, CFG_WIDTH, '0, '{ACT_EMIT, 16'h7777, 16'h8888, 16'h9999},
                            1, NOT_READY_PIXEL});
    script_rows.push_back('{0, CFG_WIDTH, '0, '{ACT_LOAD, 16'hBEEF, 16'hCAFE, 16'hD00D},
                            1, BLANK_PIXEL});
    for (int i = 0; i < 3; i++)
      script_rows.push_back('{0, CFG_WIDTH, '0, '{ACT_EMIT, '0, '0, '0}, 0, BLANK_PIXEL});
    // cut the height mid-frame: held count now covers the frame and the
    // output position falls outside it, so emission restarts
    script_rows.push_back('{1, CFG_HEIGHT, 9'd1, '0, 0, BLANK_PIXEL});
    for (int i = 0; i < 3; i++)
      script_rows.push_back('{0, CFG_WIDTH, '0, '{ACT_EMIT, '0, '0, '0}, 0, BLANK_PIXEL});
    // sizes above the limit act as 256 x 256: empty frame again
    script_rows.push_back('{1, CFG_WIDTH,  9'd511, '0, 0, BLANK_PIXEL});
    script_rows.push_back('{1, CFG_HEIGHT, 9'd257, '0, 0, BLANK_PIXEL});
    script_rows.push_back('{0, CFG_WIDTH, '0, '{ACT_EMIT, '0, '0, '0}, 1, NOT_READY_PIXEL});
    // 1 x 1 frame, turn written with only bit 0 meaningful, plus a dead index
    script_rows.push_back('{1, CFG_WIDTH,  9'd0,     '0, 0, BLANK_PIXEL});
    script_rows.push_back('{1, CFG_HEIGHT, 9'd0,     '0, 0, BLANK_PIXEL});
    script_rows.push_back('{1, CFG_TURN,   9'h1FE,   '0, 0, BLANK_PIXEL});
    script_rows.push_back('{1, CFG_UNUSED, 9'h155,   '0, 0, BLANK_PIXEL});
    script_rows.push_back('{0, CFG_WIDTH, '0, '{ACT_LOAD, 16'h1234, 16'h8000, 16'h7FFF},
                            1, BLANK_PIXEL});
    script_rows.push_back('{0, CFG_WIDTH, '0, '{ACT_EMIT, '0, '0, '0}, 1,
                            '{16'h1234, 16'h8000, 16'h7FFF, 1'b1, 1'b0}});

    // hold reset, then release once
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the script; register writes only once the block has drained
    foreach (script_rows[i]) begin
      if (script_rows[i].is_cfg) begin
        wait_idle();
        write_reg(script_rows[i].idx, script_rows[i].data);
      end else begin
        push_request(script_rows[i].req, script_rows[i].typed, script_rows[i].want);
      end
    end

    // Random phases: new sizes and idling mode each time. Most phases are a
    // whole frame of loads followed by its emits; the rest are random mixes
    // that leave frames partial or overfull for the next phase to inherit.
    phase = 0;
    sent  = 0;
    while (sent < RANDOM_ITEMS || phase < MIN_PHASES) begin
      wait_idle();
      send_idle_pct  = SEND_IDLE_PCT[phase % 4];
      recv_stall_pct = RECV_STALL_PCT[phase % 4];
      if (phase == 3) begin
        // widest frame, one row
        wd = CFG_DATA_W'($urandom_range(MAX_DIM, 511));
        ht = CFG_DATA_W'($urandom_range(0, 1));
      end else if (phase == 7) begin
        // tallest frame, one column
        wd = CFG_DATA_W'($urandom_range(0, 1));
        ht = CFG_DATA_W'($urandom_range(MAX_DIM, 511));
      end else if (phase == 2) begin
        // enough requests to keep offering items through the long hold-off
        wd = CFG_DATA_W'(8);
        ht = CFG_DATA_W'(8);
      end else begin
        wd = ($urandom_range(7) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 8));
        ht = ($urandom_range(7) == 0) ? '0 : CFG_DATA_W'($urandom_range(1, 8));
      end
      write_reg(CFG_WIDTH, wd);
      write_reg(CFG_HEIGHT, ht);
      write_reg(CFG_TURN, CFG_DATA_W'($urandom));
      total = dim_eff(reg_width) * dim_eff(reg_height);

      // back-pressure: hold the result side while requests keep coming
      if (phase == 2) hold_requests++;

      if (phase == 2 || $urandom_range(9) < 7) begin
        for (int k = 0; k < total; k++) begin
          if ($urandom_range(15) == 0) begin
            push_request(random_req(ACT_EMIT), 0, BLANK_PIXEL);
            sent++;
          end
          push_request(random_req(ACT_LOAD), 0, BLANK_PIXEL);
          sent++;
        end
        if ($urandom_range(3) == 0) begin
          push_request(random_req(ACT_LOAD), 0, BLANK_PIXEL);
          sent++;
        end
        for (int k = 0; k < total; k++) begin
          push_request(random_req(ACT_EMIT), 0, BLANK_PIXEL);
          sent++;
        end
      end else begin
        n = $urandom_range(1, 2 * total);
        for (int k = 0; k < n; k++) begin
          push_request(random_req(1'($urandom)), 0, BLANK_PIXEL);
          sent++;
        end
      end
      phase++;
    end

    // drain and decide
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_idle();
    if (mismatch_count == 0 && expected_pixels.size() == 0)
      $display("image_rotate_quarter_turn_unit regression: pass");
    else
      $display("image_rotate_quarter_turn_unit regression: fail");
    $finish;
  end

endmodule
